FILE: hw/rtl/volume_spike_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the volume spike detector
// Implication checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef VOLUME_SPIKE_DETECTOR_UNIT_ASSERT_SVH
`define VOLUME_SPIKE_DETECTOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define VSD_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
`define VSD_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define VSD_ASSERT_IMP(lbl, cond, prop)
`define VSD_ASSERT_NXT(lbl, cond, prop)
`endif

`endif

FILE: hw/rtl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared widths, register indexes and the front-to-back item type.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int VOL_W       = 32;
    localparam int WL_W        = 7;
    localparam int THR_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPIKE_THRESHOLD = 8'd1;

    localparam logic [WL_W-1:0]  WL_RESET  = 7'd20;
    localparam logic [THR_W-1:0] THR_RESET = 16'd512;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [VOL_W-1:0] vol;
        logic [VOL_W-1:0] old_vol;
        logic             sub_old;
        logic             full;
        logic             clear;
    } vsd_item_t;

endpackage

FILE: hw/rtl/vsd_front.sv
// ----------------------------------------------------------------------------
// vsd_front
// Accepts samples, tracks ring slot and fill, swaps the sample into the ring.
// ----------------------------------------------------------------------------
module vsd_front
    import vsd_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1),
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LEN_W-1:0] len,
    input  logic             restart,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VOL_W-1:0] s_vol,
    input  logic             s_start,
    output logic             q_valid,
    input  logic             q_ready,
    output vsd_item_t        q_item
);

    logic [VOL_W-1:0]  ring_mem [WINDOW_MAX];
    logic [VOL_W-1:0]  old_reg;

    logic              f_valid_reg, f_valid_next;
    logic [VOL_W-1:0]  f_vol_reg;
    logic              f_sub_reg, f_full_reg, f_clear_reg;

    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              accept, push;
    logic [SLOT_W-1:0] slot_base, slot;
    logic [LEN_W-1:0]  seen_base, seen_inc, slot_inc;
    logic              sub_old, full;

    assign push    = f_valid_reg && q_ready;
    assign s_ready = !f_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        slot_base = s_start ? '0 : slot_reg;
        seen_base = s_start ? '0 : seen_reg;
        slot      = (LEN_W'(slot_base) >= len) ? '0 : slot_base;
        sub_old   = seen_base >= len;
        seen_inc  = (seen_base < len) ? seen_base + 1'b1 : seen_base;
        full      = seen_inc >= len;
        slot_inc  = LEN_W'(slot) + 1'b1;
        seen_next = seen_reg;
        slot_next = slot_reg;
        if (restart) begin
            seen_next = '0;
            slot_next = '0;
        end else if (accept) begin
            seen_next = seen_inc;
            slot_next = (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
        end
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            slot_reg    <= '0;
            f_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            slot_reg    <= slot_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // read-first: old_reg gets the entry being replaced
    always_ff @(posedge aclk) begin
        if (accept) begin
            old_reg        <= ring_mem[slot];
            ring_mem[slot] <= s_vol;
            f_vol_reg      <= s_vol;
            f_sub_reg      <= sub_old;
            f_full_reg     <= full;
            f_clear_reg    <= s_start;
        end
    end

    assign q_valid        = f_valid_reg;
    assign q_item.vol     = f_vol_reg;
    assign q_item.old_vol = old_reg;
    assign q_item.sub_old = f_sub_reg;
    assign q_item.full    = f_full_reg;
    assign q_item.clear   = f_clear_reg;

endmodule

FILE: hw/rtl/vsd_queue.sv
// ----------------------------------------------------------------------------
// vsd_queue
// Small FIFO of classified samples between front and back.
// ----------------------------------------------------------------------------
module vsd_queue
    import vsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vsd_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output vsd_item_t out_item
);

    vsd_item_t          q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/vsd_back.sv
// ----------------------------------------------------------------------------
// vsd_back
// Running sum, cross-multiplied threshold test and output register.
// ----------------------------------------------------------------------------
module vsd_back
    import vsd_pkg::*;
#(
    parameter int WINDOW_MAX          = 64,
    parameter int THRESHOLD_FRAC_BITS = 8,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LEN_W-1:0] len,
    input  logic [THR_W-1:0] threshold,
    input  logic             restart,
    input  logic             q_valid,
    output logic             q_ready,
    input  vsd_item_t        q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_spike,
    output logic             m_full
);

    localparam int SUM_W  = VOL_W + ((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1);
    localparam int PROD_W = VOL_W + LEN_W;
    localparam int RHS_W  = THR_W + SUM_W;
    localparam int LHS_W  = PROD_W + THRESHOLD_FRAC_BITS;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic              adv, pop;
    logic [SUM_W-1:0]  sum_reg, sum_next, sum_base;

    logic              b1_valid_reg, b1_full_reg;
    logic [VOL_W-1:0]  b1_vol_reg;
    logic              b2_valid_reg, b2_full_reg;
    logic [PROD_W-1:0] lhs_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic              m_valid_reg, m_spike_reg, m_full_reg;
    logic [CMP_W-1:0]  lhs_cmp, rhs_cmp;

    assign adv     = !m_valid_reg || m_ready;
    assign pop     = adv && q_valid;
    assign q_ready = adv;

    always_comb begin
        sum_base = q_item.clear ? '0 : sum_reg;
        sum_next = sum_base + SUM_W'(q_item.vol)
                 - (q_item.sub_old ? SUM_W'(q_item.old_vol) : '0);
        lhs_cmp  = CMP_W'(lhs_reg) << THRESHOLD_FRAC_BITS;
        rhs_cmp  = CMP_W'(rhs_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (restart) begin
                sum_reg <= '0;
            end else if (pop) begin
                sum_reg <= sum_next;
            end
            if (adv) begin
                b1_valid_reg <= q_valid;
                b2_valid_reg <= b1_valid_reg;
                m_valid_reg  <= b2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_vol_reg  <= q_item.vol;
            b1_full_reg <= q_item.full;
            lhs_reg     <= PROD_W'(b1_vol_reg) * PROD_W'(len);
            rhs_reg     <= RHS_W'(threshold) * RHS_W'(sum_reg);
            b2_full_reg <= b1_full_reg;
            m_full_reg  <= b2_full_reg;
            m_spike_reg <= b2_full_reg && (lhs_cmp > rhs_cmp);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_spike = m_spike_reg;
    assign m_full  = m_full_reg;

endmodule

FILE: hw/rtl/volume_spike_detector_unit.sv
// ----------------------------------------------------------------------------
// volume_spike_detector_unit
// Flags volume samples above a multiple of the moving window average.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[31:0] is the volume, s_tuser[0] starts a new series.
// Output stream: one transfer per input; m_tdata[0] spike, m_tuser[0] full.
// Config channel: cfg_index 0 = window_length (cfg_data[6:0]),
//   cfg_index 1 = spike_threshold (cfg_data[15:0], unsigned Q8.8);
//   other indexes are ignored. cfg_ready is always high. Writing
//   window_length restarts the series. Write only while the block is idle.
// Throughput: one sample per cycle while the output is not stalled, set by the
//   running-sum update in the back end and one ring read plus write per cycle.
// Pipeline: m_tvalid rises after the input transfer has passed the front
//   register and then the queue, sum, multiply and compare registers.
// Reset: clears fill count, ring slot, running sum and queue; registers
//   return to 20 and 512. The ring needs no clearing pass.
// Output stall: the back end freezes, the 4-entry queue absorbs the front,
//   then s_tready drops.
// ----------------------------------------------------------------------------
`include "volume_spike_detector_unit_assert.svh"

module volume_spike_detector_unit
    import vsd_pkg::*;
#(
    parameter int WINDOW_MAX          = 64,
    parameter int THRESHOLD_FRAC_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] volume
    input  logic [0:0]             s_tuser,   // [0] start_series
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] spike, [7:1] zero
    output logic [0:0]             m_tuser,   // [0] window_full
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    logic [WL_W-1:0]  window_length_reg;
    logic [THR_W-1:0] threshold_reg;
    logic             cfg_write, restart;
    logic [31:0]      wl_ext, len_ext;
    logic [LEN_W-1:0] len;

    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    vsd_item_t        fq_item, qb_item;
    logic             spike, full;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && (cfg_index == CFG_WINDOW_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WL_RESET;
            threshold_reg     <= THR_RESET;
        end else if (cfg_write) begin
            if (cfg_index == CFG_WINDOW_LENGTH) begin
                window_length_reg <= cfg_data[WL_W-1:0];
            end else if (cfg_index == CFG_SPIKE_THRESHOLD) begin
                threshold_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    always_comb begin
        wl_ext  = 32'(window_length_reg);
        len_ext = wl_ext;
        if (wl_ext == 32'd0) begin
            len_ext = 32'd1;
        end else if (wl_ext > 32'(WINDOW_MAX)) begin
            len_ext = 32'(WINDOW_MAX);
        end
        len = len_ext[LEN_W-1:0];
    end

    vsd_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .len     (len),
        .restart (restart),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_vol   (s_tdata),
        .s_start (s_tuser[0]),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    vsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    vsd_back #(
        .WINDOW_MAX          (WINDOW_MAX),
        .THRESHOLD_FRAC_BITS (THRESHOLD_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .len       (len),
        .threshold (threshold_reg),
        .restart   (restart),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_spike   (spike),
        .m_full    (full)
    );

    assign m_tdata = {7'd0, spike};
    assign m_tuser = full;

    `VSD_ASSERT_IMP(a_spike_needs_full, m_tvalid && m_tdata[0], m_tuser[0])
    `VSD_ASSERT_NXT(a_front_holds, fq_valid && !fq_ready, fq_valid)
    `VSD_ASSERT_NXT(a_queue_holds, qb_valid && !qb_ready, qb_valid)

endmodule
